FILE: design/tlvp_pkg.sv
`default_nettype none

package tlvp_pkg;

    // Parse phase codes, held in a plain 4-bit state vector.
    localparam logic [3:0] PH_MAGIC_HI = 4'd0;
    localparam logic [3:0] PH_MAGIC_LO = 4'd1;
    localparam logic [3:0] PH_VERSION  = 4'd2;
    localparam logic [3:0] PH_COUNT    = 4'd3;
    localparam logic [3:0] PH_TYPE     = 4'd4;
    localparam logic [3:0] PH_LEN_HI   = 4'd5;
    localparam logic [3:0] PH_LEN_LO   = 4'd6;
    localparam logic [3:0] PH_VALUE    = 4'd7;
    localparam logic [3:0] PH_LABEL    = 4'd8;
    localparam logic [3:0] PH_AFTER    = 4'd9;
    localparam logic [3:0] PH_DISCARD  = 4'd10;

    // Role codes attached to every byte.
    localparam logic [3:0] ROLE_MAGIC   = 4'd0;
    localparam logic [3:0] ROLE_VERSION = 4'd1;
    localparam logic [3:0] ROLE_COUNT   = 4'd2;
    localparam logic [3:0] ROLE_TYPE    = 4'd3;
    localparam logic [3:0] ROLE_LENGTH  = 4'd4;
    localparam logic [3:0] ROLE_VALUE   = 4'd5;
    localparam logic [3:0] ROLE_LABEL   = 4'd6;
    localparam logic [3:0] ROLE_AFTER   = 4'd7;
    localparam logic [3:0] ROLE_DISCARD = 4'd8;

    // Error codes.
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_BAD_MAGIC = 2'd1;
    localparam logic [1:0] ERR_TRUNC     = 2'd2;
    localparam logic [1:0] ERR_TOO_MANY  = 2'd3;

    // Per-packet parser context.
    typedef struct packed {
        logic [3:0]  phase;
        logic [7:0]  magic_high;
        logic [7:0]  fields_declared;
        logic [7:0]  field_counter;
        logic [7:0]  current_type;
        logic [15:0] current_length;
        logic [15:0] bytes_left;
        logic [7:0]  version;
        logic [1:0]  error;
    } parse_state_t;

    // One tagged result item.
    typedef struct packed {
        logic [3:0]  byte_role;
        logic [7:0]  byte_out;
        logic [7:0]  field_number;
        logic [7:0]  type_code;
        logic [15:0] value_length;
        logic [7:0]  version_seen;
        logic [1:0]  error_code;
        logic        packet_done;
    } result_t;

endpackage

`default_nettype wire

FILE: design/tlvp_in_if.sv
`default_nettype none

interface tlvp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       packet_end;

    modport source (output valid, output data_byte, output packet_end, input ready);
    modport sink (input valid, input data_byte, input packet_end, output ready);
endinterface

`default_nettype wire

FILE: design/tlvp_out_if.sv
`default_nettype none

interface tlvp_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  byte_role;
    logic [7:0]  byte_out;
    logic [7:0]  field_number;
    logic [7:0]  type_code;
    logic [15:0] value_length;
    logic [7:0]  version_seen;
    logic [1:0]  error_code;
    logic        packet_done;

    modport source (
        output valid, output byte_role, output byte_out, output field_number,
        output type_code, output value_length, output version_seen,
        output error_code, output packet_done, input ready
    );
    modport sink (
        input valid, input byte_role, input byte_out, input field_number,
        input type_code, input value_length, input version_seen,
        input error_code, input packet_done, output ready
    );
endinterface

`default_nettype wire

FILE: design/tlvp_cfg_if.sv
`default_nettype none

interface tlvp_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] magic_value;

    modport source (output valid, output magic_value, input ready);
    modport sink (input valid, input magic_value, output ready);
endinterface

`default_nettype wire

FILE: design/tlvp_step.sv
`default_nettype none

module tlvp_step
    import tlvp_pkg::*;
#(
    parameter int FIELD_LIMIT = 16,
    parameter int LABEL_BYTES = 32,
    parameter int LCW         = $clog2(LABEL_BYTES)
) (
    input  parse_state_t   cur,
    input  logic [LCW-1:0] label_count,
    input  logic [7:0]     data_byte,
    input  logic           packet_end,
    input  logic [15:0]    magic_value,
    output parse_state_t   nxt,
    output logic [LCW-1:0] label_count_next,
    output result_t        res
);

    localparam logic [7:0]     LIMIT     = 8'(FIELD_LIMIT);
    localparam logic [LCW-1:0] LABEL_MAX = LCW'(LABEL_BYTES - 1);

    parse_state_t   st;
    logic [LCW-1:0] lc;
    logic [3:0]     role;
    logic [7:0]     fc_inc;
    logic [15:0]    len_full;
    logic [15:0]    left_dec;

    assign fc_inc   = cur.field_counter + 8'd1;
    assign len_full = {cur.current_length[15:8], data_byte};
    assign left_dec = cur.bytes_left - 16'd1;

    // Advance the parse context by one byte and tag the byte with its role.
    always_comb
    begin
        st   = cur;
        lc   = label_count;
        role = ROLE_DISCARD;
        case (cur.phase)
            PH_MAGIC_HI:
            begin
                role          = ROLE_MAGIC;
                st.magic_high = data_byte;
                st.phase      = PH_MAGIC_LO;
            end
            PH_MAGIC_LO:
            begin
                role = ROLE_MAGIC;
                if (!packet_end && ({cur.magic_high, data_byte} != magic_value))
                begin
                    st.error = ERR_BAD_MAGIC;
                    st.phase = PH_DISCARD;
                end
                else
                begin
                    st.phase = PH_VERSION;
                end
            end
            PH_VERSION:
            begin
                role       = ROLE_VERSION;
                st.version = data_byte;
                st.phase   = PH_COUNT;
            end
            PH_COUNT:
            begin
                role               = ROLE_COUNT;
                st.fields_declared = data_byte;
                st.field_counter   = 8'd0;
                if (data_byte > LIMIT)
                begin
                    st.error = ERR_TOO_MANY;
                    st.phase = PH_DISCARD;
                end
                else
                begin
                    st.phase = (data_byte == 8'd0) ? PH_LABEL : PH_TYPE;
                end
            end
            PH_TYPE:
            begin
                role              = ROLE_TYPE;
                st.current_type   = data_byte;
                st.current_length = 16'd0;
                st.phase          = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                role              = ROLE_LENGTH;
                st.current_length = {data_byte, 8'd0};
                st.phase          = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                role              = ROLE_LENGTH;
                st.current_length = len_full;
                st.bytes_left     = len_full;
                if (len_full == 16'd0)
                begin
                    st.field_counter = fc_inc;
                    st.phase = (fc_inc >= cur.fields_declared) ? PH_LABEL : PH_TYPE;
                end
                else
                begin
                    st.phase = PH_VALUE;
                end
            end
            PH_VALUE:
            begin
                role          = ROLE_VALUE;
                st.bytes_left = left_dec;
                if (left_dec == 16'd0)
                begin
                    st.field_counter = fc_inc;
                    st.phase = (fc_inc >= cur.fields_declared) ? PH_LABEL : PH_TYPE;
                end
            end
            PH_LABEL:
            begin
                if (data_byte == 8'd0)
                begin
                    role     = ROLE_LABEL;
                    st.phase = PH_AFTER;
                end
                else if (label_count < LABEL_MAX)
                begin
                    role = ROLE_LABEL;
                    lc   = label_count + LCW'(1);
                end
                else
                begin
                    role     = ROLE_AFTER;
                    st.phase = PH_AFTER;
                end
            end
            PH_AFTER:
            begin
                role = ROLE_AFTER;
            end
            default:
            begin
                role     = ROLE_DISCARD;
                st.phase = PH_DISCARD;
            end
        endcase

        // A packet that ends before its header or fields are complete is truncated.
        if (packet_end && (st.error == ERR_NONE) && !(st.phase inside
            {PH_LABEL, PH_AFTER, PH_DISCARD}))
        begin
            st.error = ERR_TRUNC;
        end
    end

    // The result reflects the context after this byte.
    always_comb
    begin
        res.byte_role    = role;
        res.byte_out     = data_byte;
        res.field_number = st.field_counter;
        res.type_code    = st.current_type;
        res.value_length = st.current_length;
        res.version_seen = st.version;
        res.error_code   = st.error;
        res.packet_done  = packet_end;
    end

    // The last byte of a packet clears the context for the next one.
    always_comb
    begin
        if (packet_end)
        begin
            nxt              = '0;
            label_count_next = '0;
        end
        else
        begin
            nxt              = st;
            label_count_next = lc;
        end
    end

endmodule

`default_nettype wire

FILE: design/tlv_packet_stream_parser_core.sv
`default_nettype none

// Channel   Modport  Payload                                      Accepted when
// packet    sink     data_byte[7:0], packet_end                   valid && ready
// result    source   byte_role .. packet_done (tagged byte)       valid && ready
// cfg       sink     magic_value[15:0]                            valid && ready
//
// Each byte is parsed on the edge that accepts it, and its tagged result is
// visible in the output register in the following cycle.
// A new byte is accepted every cycle; the output register is the only buffer,
// so packet.ready drops only while a result waits and result.ready is low.
// Reset (rst_n low, asynchronous) clears the parse context, the magic register
// and the output valid flag. The cfg channel is always ready.

module tlv_packet_stream_parser_core
    import tlvp_pkg::*;
#(
    parameter int FIELD_LIMIT = 16,
    parameter int LABEL_BYTES = 32
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    tlvp_in_if.sink    packet,
    tlvp_out_if.source result,
    tlvp_cfg_if.sink   cfg
);

    localparam int LCW = $clog2(LABEL_BYTES);

    parse_state_t   state_reg;
    parse_state_t   state_next;
    logic [LCW-1:0] label_count_reg;
    logic [LCW-1:0] label_count_next;
    logic [15:0]    magic_reg;
    result_t        res_reg;
    result_t        res_next;
    logic           out_valid_reg;
    logic           accept;

    // Take a byte whenever the output register is empty or being drained.
    assign packet.ready = !out_valid_reg || result.ready;
    assign accept       = packet.valid && packet.ready;
    assign cfg.ready    = 1'b1;

    tlvp_step #(
        .FIELD_LIMIT (FIELD_LIMIT),
        .LABEL_BYTES (LABEL_BYTES),
        .LCW         (LCW)
    ) u_step (
        .cur              (state_reg),
        .label_count      (label_count_reg),
        .data_byte        (packet.data_byte),
        .packet_end       (packet.packet_end),
        .magic_value      (magic_reg),
        .nxt              (state_next),
        .label_count_next (label_count_next),
        .res              (res_next)
    );

    // Magic register written from the configuration channel.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_reg <= 16'd0;
        end
        else if (cfg.valid)
        begin
            magic_reg <= cfg.magic_value;
        end
    end

    // Parse context advances on every accepted item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= '0;
            label_count_reg <= '0;
        end
        else if (accept)
        begin
            state_reg       <= state_next;
            label_count_reg <= label_count_next;
        end
    end

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (packet.ready)
        begin
            out_valid_reg <= packet.valid;
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.byte_role    = res_reg.byte_role;
    assign result.byte_out     = res_reg.byte_out;
    assign result.field_number = res_reg.field_number;
    assign result.type_code    = res_reg.type_code;
    assign result.value_length = res_reg.value_length;
    assign result.version_seen = res_reg.version_seen;
    assign result.error_code   = res_reg.error_code;
    assign result.packet_done  = res_reg.packet_done;

`ifndef SYNTHESIS
    // The last byte of a packet always returns the parser to the magic phase.
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && packet.packet_end) |=> (state_reg.phase == PH_MAGIC_HI))
        else $error("parse context not cleared after packet end");

    // An error stays set for the rest of its packet.
    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !packet.packet_end && (state_reg.error != ERR_NONE))
        |=> (state_reg.error == $past(state_reg.error)))
        else $error("error code changed within a packet");

    // A discarded byte only follows a bad magic or an oversized field count.
    a_discard_err: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && (result.byte_role == ROLE_DISCARD))
        |-> ((result.error_code == ERR_BAD_MAGIC) || (result.error_code == ERR_TOO_MANY)))
        else $error("discarded byte without a rejecting error");

    // The field counter never runs past the declared count.
    a_counter_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.field_counter <= state_reg.fields_declared)
        else $error("field counter exceeds declared count");
`endif

endmodule

`default_nettype wire
